// ===== rtl/newell_face_and_vertex_normals_unit_defines.svh =====
// Assertion macros for the Newell face and vertex normal unit.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef NEWELL_FACE_AND_VERTEX_NORMALS_UNIT_DEFINES_SVH
`define NEWELL_FACE_AND_VERTEX_NORMALS_UNIT_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define NFVN_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// When pre holds, post must hold in the same cycle.
`define NFVN_ASSERT_IMP(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

`endif

// ===== rtl/nfvn_pkg.sv =====
// Shared types and constants for the Newell face and vertex normal unit.
// No dependencies; imported by nfvn_norm and the top level.
package nfvn_pkg;

   localparam int TABLE_DEPTH_DEF      = 1024;
   localparam int MAX_FACE_VERTS_DEF   = 16;
   localparam int NORMAL_FRAC_BITS_DEF = 14;

   localparam int OP_W    = 2;
   localparam int IDX_W   = 10;
   localparam int COORD_W = 24;
   localparam int VSUM_W  = 24;
   localparam int SUM_W   = 56;
   localparam int NORM_W  = 16;
   localparam int STAT_W  = 2;
   localparam int MAG_W   = 30;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD = 2'd0,
      OP_FACE = 2'd1,
      OP_READ = 2'd2
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_ZERO     = 2'd1,
      STAT_OVERSIZE = 2'd2
   } status_type;

   localparam logic KIND_FACE   = 1'b0;
   localparam logic KIND_VERTEX = 1'b1;

   typedef struct packed {
      logic done;
      logic zero;
   } norm_stat_type;

   typedef enum logic [3:0] {
      N_IDLE, N_MAX, N_SHIFT, N_SQ, N_SQRT, N_DINIT, N_DCHK, N_DSTEP, N_DSTORE, N_DONE
   } norm_state_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_MOD, ST_DISPATCH, ST_CLOSE, ST_EDGE_RDA, ST_EDGE_RDB,
      ST_EDGE_LATB, ST_EDGE_MUL, ST_EDGE_ACC, ST_NORM_START, ST_NORM_WAIT,
      ST_WALK_RD, ST_WALK_WR, ST_OVERSIZE, ST_EMIT
   } ctrl_state_type;

endpackage

// ===== rtl/nfvn_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module nfvn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/nfvn_norm.sv =====
// Iterative vector normalizer: range reduction, sum of squares, bit-serial
// square root and restoring division per component. Depends on nfvn_pkg.
module nfvn_norm #(
   parameter int FRAC_BITS = nfvn_pkg::NORMAL_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [nfvn_pkg::SUM_W-1:0]    vec_x,
   input  logic signed [nfvn_pkg::SUM_W-1:0]    vec_y,
   input  logic signed [nfvn_pkg::SUM_W-1:0]    vec_z,
   output nfvn_pkg::norm_stat_type              stat,
   output logic signed [nfvn_pkg::NORM_W-1:0]   n_x,
   output logic signed [nfvn_pkg::NORM_W-1:0]   n_y,
   output logic signed [nfvn_pkg::NORM_W-1:0]   n_z
);
   import nfvn_pkg::*;

   localparam int SQ_W  = 2 * MAG_W;
   localparam int RT_W  = SQ_W + 4;
   localparam int QW    = NORM_W - 1;
   localparam int NUM_W = MAG_W + FRAC_BITS + 1;
   localparam int LIM_W = MAG_W + 1 + QW + 1;
   localparam int DW    = (NUM_W > LIM_W) ? NUM_W : LIM_W;

   norm_state_type          state_ff, state_in;
   logic [2:0]              neg_ff, neg_in;
   logic [SUM_W-1:0]        mag_ff [3];
   logic [SUM_W-1:0]        mag_in [3];
   logic [SUM_W-1:0]        m_ff, m_in;
   logic [SQ_W-1:0]         prod_ff, prod_in;
   logic [RT_W-1:0]         v_ff, v_in;
   logic [RT_W-1:0]         res_ff, res_in;
   logic [RT_W-1:0]         bit_ff, bit_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic [1:0]              ci_ff, ci_in;
   logic [DW-1:0]           num_ff, num_in;
   logic [DW-1:0]           dsor_ff, dsor_in;
   logic [QW-1:0]           q_ff, q_in;
   logic signed [NORM_W-1:0] n_ff [3];
   logic signed [NORM_W-1:0] n_in [3];
   logic                    zero_ff, zero_in;

   logic [RT_W-1:0]         trial;
   logic [MAG_W-1:0]        mag_sel;
   logic signed [NORM_W-1:0] q_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         state_ff <= state_in;
      end
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      m_ff    <= m_in;
      prod_ff <= prod_in;
      v_ff    <= v_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      cnt_ff  <= cnt_in;
      ci_ff   <= ci_in;
      num_ff  <= num_in;
      dsor_ff <= dsor_in;
      q_ff    <= q_in;
      n_ff    <= n_in;
      zero_ff <= zero_in;
   end

   assign trial   = res_ff + bit_ff;
   assign mag_sel = mag_ff[ci_ff][MAG_W-1:0];
   assign q_ext   = signed'({1'b0, q_ff});

   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      m_in     = m_ff;
      prod_in  = prod_ff;
      v_in     = v_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      cnt_in   = cnt_ff;
      ci_in    = ci_ff;
      num_in   = num_ff;
      dsor_in  = dsor_ff;
      q_in     = q_ff;
      n_in     = n_ff;
      zero_in  = zero_ff;
      case (state_ff)
         N_IDLE: begin
            if (start) begin
               neg_in    = {vec_z[SUM_W-1], vec_y[SUM_W-1], vec_x[SUM_W-1]};
               mag_in[0] = vec_x[SUM_W-1] ? SUM_W'(-vec_x) : SUM_W'(vec_x);
               mag_in[1] = vec_y[SUM_W-1] ? SUM_W'(-vec_y) : SUM_W'(vec_y);
               mag_in[2] = vec_z[SUM_W-1] ? SUM_W'(-vec_z) : SUM_W'(vec_z);
               state_in  = N_MAX;
            end
         end
         N_MAX: begin
            m_in = mag_ff[0];
            if (mag_ff[1] > m_in) m_in = mag_ff[1];
            if (mag_ff[2] > m_in) m_in = mag_ff[2];
            state_in = N_SHIFT;
         end
         N_SHIFT: begin
            if (m_ff == '0) begin
               zero_in = 1'b1;
               n_in[0] = '0;
               n_in[1] = '0;
               n_in[2] = '0;
               state_in = N_DONE;
            end else if (|m_ff[SUM_W-1:MAG_W]) begin
               m_in      = m_ff >> 1;
               mag_in[0] = mag_ff[0] >> 1;
               mag_in[1] = mag_ff[1] >> 1;
               mag_in[2] = mag_ff[2] >> 1;
            end else begin
               zero_in  = 1'b0;
               cnt_in   = '0;
               v_in     = '0;
               state_in = N_SQ;
            end
         end
         N_SQ: begin
            // square one component per cycle, add the previous square
            if (cnt_ff < 5'd3) begin
               prod_in = mag_ff[cnt_ff[1:0]][MAG_W-1:0] * mag_ff[cnt_ff[1:0]][MAG_W-1:0];
            end
            if (cnt_ff != 5'd0) begin
               v_in = v_ff + RT_W'(prod_ff);
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd3) begin
               res_in   = '0;
               bit_in   = RT_W'(1) << (RT_W - 2);
               cnt_in   = 5'(RT_W / 2 - 1);
               state_in = N_SQRT;
            end
         end
         N_SQRT: begin
            if (v_ff >= trial) begin
               v_in   = v_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               ci_in    = 2'd0;
               state_in = N_DINIT;
            end
         end
         N_DINIT: begin
            num_in   = (DW'(mag_sel) << FRAC_BITS) + (DW'(res_ff) >> 1);
            dsor_in  = DW'(res_ff) << QW;
            state_in = N_DCHK;
         end
         N_DCHK: begin
            if (num_ff >= dsor_ff) begin
               q_in     = '1;
               state_in = N_DSTORE;
            end else begin
               q_in     = '0;
               dsor_in  = dsor_ff >> 1;
               cnt_in   = 5'(QW - 1);
               state_in = N_DSTEP;
            end
         end
         N_DSTEP: begin
            if (num_ff >= dsor_ff) begin
               num_in = num_ff - dsor_ff;
               q_in   = {q_ff[QW-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[QW-2:0], 1'b0};
            end
            dsor_in = dsor_ff >> 1;
            cnt_in  = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) state_in = N_DSTORE;
         end
         N_DSTORE: begin
            n_in[ci_ff] = neg_ff[ci_ff] ? -q_ext : q_ext;
            if (ci_ff == 2'd2) begin
               state_in = N_DONE;
            end else begin
               ci_in    = ci_ff + 2'd1;
               state_in = N_DINIT;
            end
         end
         N_DONE: begin
            state_in = N_IDLE;
         end
         default: state_in = N_IDLE;
      endcase
   end

   assign stat.done = (state_ff == N_DONE);
   assign stat.zero = zero_ff;
   assign n_x = n_ff[0];
   assign n_y = n_ff[1];
   assign n_z = n_ff[2];
endmodule

// ===== rtl/newell_face_and_vertex_normals_unit.sv =====
// Top level: vertex and normal-sum tables, face sequencer, edge multiplier.
// Depends on nfvn_pkg, nfvn_ram, nfvn_norm and the assertion macro header.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   operation, index, coords, last flag
//   rsp      out        rsp_valid/rsp_ready   kind, normal xyz, status, echo index
//
// After reset a clearing pass zeroes the normal sums, with ready low.
// Every index is first folded below TABLE_DEPTH by repeated subtraction; a load then writes it.
// Face vertex: with an edge, two table reads and three multiplies on the shared multiplier;
// the last vertex adds the closing edge.
// Read or last face vertex: the normalizer stops early on a zero vector, else runs the
// range-reduction shifts, a 32-step square root and three 15-step divisions;
// a face then adds its nonzero normal into the sum of each of its vertices.
// One item at a time; a result waits in the output register while the next is taken.
`include "newell_face_and_vertex_normals_unit_defines.svh"
module newell_face_and_vertex_normals_unit #(
   parameter int TABLE_DEPTH      = nfvn_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_FACE_VERTS   = nfvn_pkg::MAX_FACE_VERTS_DEF,
   parameter int NORMAL_FRAC_BITS = nfvn_pkg::NORMAL_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [nfvn_pkg::OP_W-1:0]             req_operation,
   input  logic [nfvn_pkg::IDX_W-1:0]            req_vertex_index,
   input  logic signed [nfvn_pkg::COORD_W-1:0]   req_coord_x,
   input  logic signed [nfvn_pkg::COORD_W-1:0]   req_coord_y,
   input  logic signed [nfvn_pkg::COORD_W-1:0]   req_coord_z,
   input  logic                                  req_last_of_face,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_result_kind,
   output logic signed [nfvn_pkg::NORM_W-1:0]    rsp_normal_x,
   output logic signed [nfvn_pkg::NORM_W-1:0]    rsp_normal_y,
   output logic signed [nfvn_pkg::NORM_W-1:0]    rsp_normal_z,
   output logic [nfvn_pkg::STAT_W-1:0]           rsp_status,
   output logic [nfvn_pkg::IDX_W-1:0]            rsp_echo_index
);
   import nfvn_pkg::*;

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CW    = $clog2(MAX_FACE_VERTS + 1);
   localparam int BW    = $clog2(MAX_FACE_VERTS);
   localparam int EW    = COORD_W + 1;
   localparam int PW    = 2 * EW;
   localparam int RAM_W = 3 * COORD_W;
   localparam logic signed [VSUM_W:0] VMAX = (VSUM_W + 1)'((1 << (VSUM_W - 1)) - 1);
   localparam logic signed [VSUM_W:0] VMIN = -VMAX - 1;

   ctrl_state_type           state_ff, state_in;
   logic [AW-1:0]            clr_ff, clr_in;
   logic [OP_W-1:0]          op_ff, op_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [IDX_W-1:0]         echo_ff, echo_in;
   logic [RAM_W-1:0]         coord_ff, coord_in;
   logic                     last_ff, last_in;
   logic [CW-1:0]            count_ff, count_in;
   logic                     ovf_ff, ovf_in;
   logic [AW-1:0]            first_ff, first_in;
   logic [AW-1:0]            prev_ff, prev_in;
   logic [AW-1:0]            buf_ff [MAX_FACE_VERTS];
   logic [AW-1:0]            buf_in [MAX_FACE_VERTS];
   logic signed [SUM_W-1:0]  sum_ff [3];
   logic signed [SUM_W-1:0]  sum_in [3];
   logic [AW-1:0]            ea_ff, ea_in;
   logic [AW-1:0]            eb_ff, eb_in;
   logic                     closing_ff, closing_in;
   logic [RAM_W-1:0]         pa_ff, pa_in;
   logic [RAM_W-1:0]         pb_ff, pb_in;
   logic [1:0]               step_ff, step_in;
   logic signed [PW-1:0]     prod_ff, prod_in;
   logic                     src_vtx_ff, src_vtx_in;
   logic [CW-1:0]            k_ff, k_in;
   logic                     res_kind_ff, res_kind_in;
   status_type               res_stat_ff, res_stat_in;
   logic                     res_blank_ff, res_blank_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_kind_ff, rsp_kind_in;
   logic signed [NORM_W-1:0] rsp_nx_ff, rsp_nx_in;
   logic signed [NORM_W-1:0] rsp_ny_ff, rsp_ny_in;
   logic signed [NORM_W-1:0] rsp_nz_ff, rsp_nz_in;
   logic [STAT_W-1:0]        rsp_stat_ff, rsp_stat_in;
   logic [IDX_W-1:0]         rsp_echo_ff, rsp_echo_in;

   logic                     pos_we, pos_re, vn_we, vn_re;
   logic [AW-1:0]            pos_ra, vn_wa, vn_ra, addr;
   logic [RAM_W-1:0]         pos_rd, vn_rd, vn_wd;
   logic                     norm_start;
   logic signed [SUM_W-1:0]  nvec [3];
   norm_stat_type            nstat;
   logic signed [NORM_W-1:0] nx, ny, nz;
   logic signed [EW-1:0]     mul_a, mul_b;
   logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz;
   logic signed [VSUM_W:0]   sat_t [3];
   logic signed [VSUM_W-1:0] sat_r [3];
   logic signed [NORM_W-1:0] nsel [3];

   nfvn_ram #(.WIDTH(RAM_W), .DEPTH(TABLE_DEPTH)) u_pos_ram (
      .clock(clock), .wr_en(pos_we), .wr_addr(addr), .wr_data(coord_ff),
      .rd_en(pos_re), .rd_addr(pos_ra), .rd_data(pos_rd)
   );

   nfvn_ram #(.WIDTH(RAM_W), .DEPTH(TABLE_DEPTH)) u_vnorm_ram (
      .clock(clock), .wr_en(vn_we), .wr_addr(vn_wa), .wr_data(vn_wd),
      .rd_en(vn_re), .rd_addr(vn_ra), .rd_data(vn_rd)
   );

   nfvn_norm #(.FRAC_BITS(NORMAL_FRAC_BITS)) u_norm (
      .clock(clock), .reset(reset), .start(norm_start),
      .vec_x(nvec[0]), .vec_y(nvec[1]), .vec_z(nvec[2]),
      .stat(nstat), .n_x(nx), .n_y(ny), .n_z(nz)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         first_ff     <= '0;
         prev_ff      <= '0;
         sum_ff[0]    <= '0;
         sum_ff[1]    <= '0;
         sum_ff[2]    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         first_ff     <= first_in;
         prev_ff      <= prev_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      echo_ff      <= echo_in;
      coord_ff     <= coord_in;
      last_ff      <= last_in;
      buf_ff       <= buf_in;
      ea_ff        <= ea_in;
      eb_ff        <= eb_in;
      closing_ff   <= closing_in;
      pa_ff        <= pa_in;
      pb_ff        <= pb_in;
      step_ff      <= step_in;
      prod_ff      <= prod_in;
      src_vtx_ff   <= src_vtx_in;
      k_ff         <= k_in;
      res_kind_ff  <= res_kind_in;
      res_stat_ff  <= res_stat_in;
      res_blank_ff <= res_blank_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_nx_ff    <= rsp_nx_in;
      rsp_ny_ff    <= rsp_ny_in;
      rsp_nz_ff    <= rsp_nz_in;
      rsp_stat_ff  <= rsp_stat_in;
      rsp_echo_ff  <= rsp_echo_in;
   end

   assign addr = AW'(idx_ff);
   assign {az, ay, ax} = pa_ff;
   assign {bz, by, bx} = pb_ff;

   // edge operand select: difference times sum of the two other axes
   always_comb begin
      case (step_ff)
         2'd0: begin
            mul_a = EW'(ay) - EW'(by);
            mul_b = EW'(az) + EW'(bz);
         end
         2'd1: begin
            mul_a = EW'(az) - EW'(bz);
            mul_b = EW'(ax) + EW'(bx);
         end
         default: begin
            mul_a = EW'(ax) - EW'(bx);
            mul_b = EW'(ay) + EW'(by);
         end
      endcase
   end

   assign nsel[0] = nx;
   assign nsel[1] = ny;
   assign nsel[2] = nz;

   // saturating add of the face normal into a vertex sum
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sat_t[i] = (VSUM_W + 1)'(signed'(vn_rd[i*COORD_W +: VSUM_W]))
                  + (VSUM_W + 1)'(nsel[i]);
         if (sat_t[i] > VMAX) begin
            sat_r[i] = VMAX[VSUM_W-1:0];
         end else if (sat_t[i] < VMIN) begin
            sat_r[i] = VMIN[VSUM_W-1:0];
         end else begin
            sat_r[i] = sat_t[i][VSUM_W-1:0];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      echo_in      = echo_ff;
      coord_in     = coord_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      first_in     = first_ff;
      prev_in      = prev_ff;
      buf_in       = buf_ff;
      sum_in       = sum_ff;
      ea_in        = ea_ff;
      eb_in        = eb_ff;
      closing_in   = closing_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      src_vtx_in   = src_vtx_ff;
      k_in         = k_ff;
      res_kind_in  = res_kind_ff;
      res_stat_in  = res_stat_ff;
      res_blank_in = res_blank_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_nx_in    = rsp_nx_ff;
      rsp_ny_in    = rsp_ny_ff;
      rsp_nz_in    = rsp_nz_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_echo_in  = rsp_echo_ff;
      pos_we       = 1'b0;
      pos_re       = 1'b0;
      pos_ra       = ea_ff;
      vn_we        = 1'b0;
      vn_wa        = addr;
      vn_wd        = '0;
      vn_re        = 1'b0;
      vn_ra        = addr;
      norm_start   = 1'b0;
      nvec[0]      = sum_ff[0];
      nvec[1]      = sum_ff[1];
      nvec[2]      = sum_ff[2];

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            vn_we  = 1'b1;
            vn_wa  = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(TABLE_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               idx_in   = req_vertex_index;
               echo_in  = req_vertex_index;
               coord_in = {req_coord_z, req_coord_y, req_coord_x};
               last_in  = req_last_of_face;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            // fold the index into the table one subtraction at a time
            if (int'(idx_ff) >= TABLE_DEPTH) begin
               idx_in = idx_ff - IDX_W'(TABLE_DEPTH);
            end else begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (op_type'(op_ff))
               OP_LOAD: begin
                  pos_we   = 1'b1;
                  vn_we    = 1'b1;
                  state_in = ST_IDLE;
               end
               OP_READ: begin
                  vn_re      = 1'b1;
                  src_vtx_in = 1'b1;
                  state_in   = ST_NORM_START;
               end
               OP_FACE: begin
                  if (count_ff >= CW'(MAX_FACE_VERTS) || ovf_ff) begin
                     ovf_in   = 1'b1;
                     state_in = last_ff ? ST_OVERSIZE : ST_IDLE;
                  end else begin
                     buf_in[count_ff[BW-1:0]] = addr;
                     count_in = count_ff + CW'(1);
                     prev_in  = addr;
                     if (count_ff == '0) begin
                        first_in = addr;
                        state_in = last_ff ? ST_CLOSE : ST_IDLE;
                     end else begin
                        ea_in      = prev_ff;
                        eb_in      = addr;
                        closing_in = 1'b0;
                        state_in   = ST_EDGE_RDA;
                     end
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_CLOSE: begin
            ea_in      = prev_ff;
            eb_in      = first_ff;
            closing_in = 1'b1;
            state_in   = ST_EDGE_RDA;
         end
         ST_EDGE_RDA: begin
            pos_re   = 1'b1;
            pos_ra   = ea_ff;
            state_in = ST_EDGE_RDB;
         end
         ST_EDGE_RDB: begin
            pa_in    = pos_rd;
            pos_re   = 1'b1;
            pos_ra   = eb_ff;
            state_in = ST_EDGE_LATB;
         end
         ST_EDGE_LATB: begin
            pb_in    = pos_rd;
            step_in  = 2'd0;
            state_in = ST_EDGE_MUL;
         end
         ST_EDGE_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_EDGE_ACC;
         end
         ST_EDGE_ACC: begin
            sum_in[step_ff] = sum_ff[step_ff] + SUM_W'(prod_ff);
            if (step_ff == 2'd2) begin
               if (closing_ff) begin
                  src_vtx_in = 1'b0;
                  state_in   = ST_NORM_START;
               end else begin
                  state_in = last_ff ? ST_CLOSE : ST_IDLE;
               end
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = ST_EDGE_MUL;
            end
         end
         ST_NORM_START: begin
            norm_start = 1'b1;
            if (src_vtx_ff) begin
               for (int i = 0; i < 3; i++) begin
                  nvec[i] = SUM_W'(signed'(vn_rd[i*COORD_W +: VSUM_W]));
               end
            end
            state_in = ST_NORM_WAIT;
         end
         ST_NORM_WAIT: begin
            if (nstat.done) begin
               res_blank_in = 1'b0;
               res_stat_in  = nstat.zero ? STAT_ZERO : STAT_OK;
               if (src_vtx_ff) begin
                  res_kind_in = KIND_VERTEX;
                  state_in    = ST_EMIT;
               end else begin
                  res_kind_in = KIND_FACE;
                  k_in        = '0;
                  state_in    = nstat.zero ? ST_EMIT : ST_WALK_RD;
               end
            end
         end
         ST_WALK_RD: begin
            vn_re    = 1'b1;
            vn_ra    = buf_ff[k_ff[BW-1:0]];
            state_in = ST_WALK_WR;
         end
         ST_WALK_WR: begin
            vn_we    = 1'b1;
            vn_wa    = buf_ff[k_ff[BW-1:0]];
            vn_wd    = {sat_r[2], sat_r[1], sat_r[0]};
            k_in     = k_ff + CW'(1);
            state_in = (k_ff + CW'(1) == count_ff) ? ST_EMIT : ST_WALK_RD;
         end
         ST_OVERSIZE: begin
            res_kind_in  = KIND_FACE;
            res_stat_in  = STAT_OVERSIZE;
            res_blank_in = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_stat_in  = res_stat_ff;
               rsp_nx_in    = res_blank_ff ? '0 : nx;
               rsp_ny_in    = res_blank_ff ? '0 : ny;
               rsp_nz_in    = res_blank_ff ? '0 : nz;
               rsp_echo_in  = (res_kind_ff == KIND_VERTEX) ? echo_ff : '0;
               if (res_kind_ff == KIND_FACE) begin
                  count_in  = '0;
                  ovf_in    = 1'b0;
                  first_in  = '0;
                  prev_in   = '0;
                  sum_in[0] = '0;
                  sum_in[1] = '0;
                  sum_in[2] = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_normal_x    = rsp_nx_ff;
   assign rsp_normal_y    = rsp_ny_ff;
   assign rsp_normal_z    = rsp_nz_ff;
   assign rsp_status      = rsp_stat_ff;
   assign rsp_echo_index  = rsp_echo_ff;

   `NFVN_ASSERT_IMP(a_clear_not_ready, state_ff == ST_CLEAR, !req_ready, "ready during clear pass")
   `NFVN_ASSERT_IMP(a_norm_done_expected, nstat.done, state_ff == ST_NORM_WAIT, "stray normalizer done")
   `NFVN_ASSERT(a_count_bound, count_ff <= CW'(MAX_FACE_VERTS), "face count beyond buffer")
   `NFVN_ASSERT_IMP(a_oversize_blank, rsp_valid && rsp_status == STAT_OVERSIZE,
      rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0, "oversize with normal")
endmodule
